@@ rtl/sitda_pkg.sv @@
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // decimal digits needed for an unsigned word of the given width (1233/4096 ~ log10 2)
  function automatic int bcd_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

endpackage

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Flow: a bit-serial double-dabble loop converts the value, a digit scan suppresses leading zeros,
//   then a minus sign for a negative value and each digit are loaded into the output register.
// A new item is taken only in idle, after the last character of the previous item is loaded,
//   so conversion and digit scan work on one item at a time.
// One character per beat; the next item is taken while the last character waits.
// Reset: synchronous, active high; clears the FSM and the output valid flag.
module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [VALUE_BITS-1:0] value
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,  // [7:0] character
  output logic                                  m_tlast   // last
);

  localparam int NDIG      = bcd_digits(VALUE_BITS);
  localparam int BCD_W     = 4 * NDIG;
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);

  state_t                 state;
  state_t                 state_next;
  logic [VALUE_BITS-1:0]  mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic                   neg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIG_CNT_W-1:0]   dig_cnt;

  logic [VALUE_BITS-1:0]  value_in;
  logic [VALUE_BITS-1:0]  mag_in;
  logic [3:0]             top_dig;
  logic                   out_free;
  logic                   conv_done;
  logic                   dig_final;
  logic                   load_in;
  logic                   do_dabble;
  logic                   do_skip;
  logic                   load_sign;
  logic                   load_digit;

  assign value_in  = s_tdata[VALUE_BITS-1:0];
  assign mag_in    = value_in[VALUE_BITS-1] ?
                     (~value_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : value_in;
  assign top_dig   = bcd[BCD_W-1 -: 4];
  assign out_free  = !m_tvalid || m_tready;
  assign conv_done = (bit_cnt == BIT_CNT_W'(VALUE_BITS - 1));
  assign dig_final = (dig_cnt == DIG_CNT_W'(1));

  // add-3 correction, each digit on its own
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (top_dig != 4'd0 || dig_final) state_next = neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && dig_final) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = (state == ST_IDLE);
    load_in    = (state == ST_IDLE) && s_tvalid;
    do_dabble  = (state == ST_CONV);
    do_skip    = (state == ST_SKIP) && top_dig == 4'd0 && !dig_final;
    load_sign  = (state == ST_SIGN) && out_free;
    load_digit = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_sign || load_digit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      neg     <= value_in[VALUE_BITS-1];
      mag     <= mag_in;
      bcd     <= '0;
      bit_cnt <= '0;
      dig_cnt <= DIG_CNT_W'(NDIG);
    end
    if (do_dabble) begin
      {bcd, mag} <= {bcd_adj[BCD_W-2:0], mag, 1'b0};
      bit_cnt    <= bit_cnt + BIT_CNT_W'(1);
    end
    if (do_skip || load_digit) begin
      bcd     <= {bcd[BCD_W-5:0], 4'd0};
      dig_cnt <= dig_cnt - DIG_CNT_W'(1);
    end
    if (load_sign) begin
      m_tdata <= CH_MINUS;
      m_tlast <= 1'b0;
    end
    if (load_digit) begin
      m_tdata <= CH_ZERO + {4'd0, top_dig};
      m_tlast <= dig_final;
    end
  end

endmodule

@@ rtl/sitda_checker.sv @@
module sitda_checker
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [7:0]                            m_tdata,
  input logic                                  m_tlast
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed under stall");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CH_MINUS && !m_tlast) ||
                 (m_tdata >= CH_ZERO && m_tdata <= CH_NINE))
    else $error("bad character or sign marked last");

  // busy converting once an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during conversion");

  a_one_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata == CH_MINUS |=> !(m_tvalid && m_tdata == CH_MINUS))
    else $error("two sign characters in a row");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid |-> !$isunknown(s_tdata))
    else $error("unknown bits in input beat");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker #(.VALUE_BITS(VALUE_BITS)) u_sitda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ bench/tb_top.sv @@
module tb_top;
  import sitda_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 60;

  // expected text per accepted value, one entry per character beat
  class decimal_text_board;
    logic [7:0] char_q[$];
    logic       last_q[$];
    int         errors;

    function void note_value(logic [VB-1:0] value);
      logic [VB-1:0] mag;
      logic [3:0]    dig[12];
      int            nd;
      int            k;
      // magnitude taken as unsigned, so the most negative value stays correct
      mag = value[VB-1] ? (~value + 1'b1) : value;
      nd  = 0;
      do begin
        dig[nd] = 4'(mag % 10);
        mag     = mag / 10;
        nd++;
      end while (mag != 0);
      if (value[VB-1]) begin
        char_q.push_back(CH_MINUS);
        last_q.push_back(1'b0);
      end
      for (k = nd - 1; k >= 0; k--) begin
        char_q.push_back(CH_ZERO + {4'd0, dig[k]});
        last_q.push_back(k == 0);
      end
    endfunction

    function void check_char(logic [7:0] character, logic last);
      logic [7:0] exp_char;
      logic       exp_last;
      if (char_q.size() == 0) begin
        $error("character beat with nothing expected: character=%h last=%b", character, last);
        errors++;
        return;
      end
      exp_char = char_q.pop_front();
      exp_last = last_q.pop_front();
      if (character !== exp_char) begin
        $error("character: expected %h, got %h", exp_char, character);
        errors++;
      end
      if (last !== exp_last) begin
        $error("last: expected %b, got %b", exp_last, last);
        errors++;
      end
    endfunction

    function int pending();
      return char_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [VB-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [7:0]    m_tdata;
  logic          m_tlast;

  int                send_idle_pct = 7;
  int                recv_idle_pct = 55;
  int                stall_cycles  = 0;
  decimal_text_board text_sb = new;

  signed_int_to_decimal_ascii_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      text_sb.check_char(m_tdata, m_tlast);
    end
  end

  // cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_value(input logic [VB-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    text_sb.note_value(value);
  endtask

  // mostly values of a chosen digit count, some raw 32-bit patterns
  task automatic send_random(input int count);
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    bit     neg;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        send_value($urandom);
      end else begin
        nd  = $urandom_range(1, 10);
        lo  = 1;
        repeat (nd - 1) lo = lo * 10;
        hi  = lo * 10 - 1;
        if (nd == 1) lo = 0;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        neg = $urandom_range(1);
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
        send_value(neg ? VB'(-mag) : VB'(mag));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_value(32'd0);
    send_value(32'd1);
    send_value(-32'sd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'sd10);
    send_value(32'd99);
    send_value(32'd100);
    send_value(-32'sd99);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);       // most negative, magnitude 2147483648
    send_value(32'h8000_0001);
    send_value(32'd1000000000);
    send_value(-32'sd1000000000);
    send_value(32'd999999999);
    send_value(32'd123456789);
    send_value(-32'sd987654321);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAA);
    send_value(32'd1073741824);
    send_value(32'd10);

    send_random(50);
    send_idle_pct = 55;
    recv_idle_pct = 7;
    send_random(50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(50);
    s_tvalid <= 1'b0;

    while (text_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (text_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
